/* rtl/hbt_pkg.sv */
// ----------------------------------------------------------------------------
// hbt_pkg - shared types and constants of the hint band table
// Band and query words, match flags, status codes and table sizing.
// ----------------------------------------------------------------------------
package hbt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int MARGIN_W    = 20;
  localparam int COORD_W     = 32;
  localparam int TAG_W       = 16;
  localparam int WIDE_W      = COORD_W + 2;
  localparam int COUNT_OUT_W = 7;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(7680);

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_CONFLICT  = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_CLEARED   = 3'd4
  } status_t;

  // one stored band: the relevant pair kept in order (lo <= hi)
  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    logic [TAG_W-1:0]   start_tag;
    logic [TAG_W-1:0]   end_tag;
  } band_t;

  // request under test: the new band and its pair widened by a quarter of the margin
  typedef struct packed {
    band_t             band;
    logic [WIDE_W-1:0] lo_w;
    logic [WIDE_W-1:0] hi_w;
  } query_t;

  typedef struct packed {
    logic hit;
    logic dup;
  } match_t;

  typedef struct packed {
    logic any_hit;
    logic dup;
  } pick_t;

endpackage

/* rtl/hbt_cell.sv */
// ----------------------------------------------------------------------------
// hbt_cell - one slot of the band chain
// Holds one band, shifts it to the older neighbor on insert, and compares it
// against the current request every cycle.
// ----------------------------------------------------------------------------
module hbt_cell
  import hbt_pkg::*;
(
  input  logic   clk,
  input  logic   shift_en,
  input  logic   occupied,
  input  band_t  band_in,
  input  query_t query,
  output band_t  band,
  output match_t match
);

  logic signed [WIDE_W-1:0] lo_ext;
  logic signed [WIDE_W-1:0] hi_ext;
  logic                     kind_eq;
  logic                     same;
  logic                     overlap;
  match_t                   match_next;

  assign lo_ext = WIDE_W'($signed(band.lo));
  assign hi_ext = WIDE_W'($signed(band.hi));

  always_comb begin
    kind_eq = occupied && (band.kind == query.band.kind);
    same    = (band.lo == query.band.lo) && (band.hi == query.band.hi);
    overlap = (lo_ext <= $signed(query.hi_w)) && ($signed(query.lo_w) <= hi_ext);
    match_next.dup = kind_eq && same;
    match_next.hit = kind_eq && (same || overlap);
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      band <= band_in;
    end
    match <= match_next;
  end

endmodule

/* rtl/hbt_pick.sv */
// ----------------------------------------------------------------------------
// hbt_pick - newest-first selection over the cell match flags
// Isolates the lowest hit (cell 0 is the newest) and reports whether it is a duplicate.
// ----------------------------------------------------------------------------
module hbt_pick
  import hbt_pkg::*;
(
  input  logic [TABLE_DEPTH-1:0] hit,
  input  logic [TABLE_DEPTH-1:0] dup,
  output pick_t                  pick
);

  logic [TABLE_DEPTH-1:0] first;

  // keep only the lowest set bit
  assign first = hit & (~hit + TABLE_DEPTH'(1));

  always_comb begin
    pick.any_hit = |hit;
    pick.dup     = |(first & dup);
  end

endmodule

/* rtl/hint_band_table.sv */
// ----------------------------------------------------------------------------
// hint_band_table - table of stem-hint bands with duplicate/conflict check
// A chain of cells holds the bands, newest in cell 0; an add is compared in
// all cells at once; the newest hit decides, else it shifts in if not full.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             word
//   request   in         start / busy          func, hint_kind, coords, tags
//   result    out        done (one cycle)      status, entry_count
//   margin    in         band_margin_we        band_margin
//
// The pair of each request is ordered and widened as it is accepted; the
// cell compares are then registered in the match flags, and the pick and the
// shift into the chain happen as status, entry_count and done are registered.
// busy is high from the accept until that result is registered, so a new
// request is accepted only once the previous result is shown.
// Reset empties the table (count to zero) and restores the margin; cell
// contents are not cleared. The receiver cannot stall: done lasts one cycle.
//
module hint_band_table
  import hbt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                func,
  input  logic [1:0]          hint_kind,
  input  logic [COORD_W-1:0]  x_start,
  input  logic [COORD_W-1:0]  y_start,
  input  logic [COORD_W-1:0]  x_end,
  input  logic [COORD_W-1:0]  y_end,
  input  logic [TAG_W-1:0]    start_tag,
  input  logic [TAG_W-1:0]    end_tag,
  input  logic                band_margin_we,
  input  logic [MARGIN_W-1:0] band_margin,
  output logic                done,
  output logic [2:0]          status,
  output logic [COUNT_OUT_W-1:0] entry_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_DEC
  } state_t;

  state_t              state;
  logic [MARGIN_W-1:0] margin;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  status_t             status_next;
  logic                accept;
  logic                q_func;
  query_t              query;
  query_t              query_next;
  logic                insert;
  logic                shift_en;
  logic                full;
  pick_t               pick;

  logic signed [WIDE_W-1:0] widen;
  logic signed [WIDE_W-1:0] pa;
  logic signed [WIDE_W-1:0] pb;
  logic                     swap;

  band_t                  chain [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit;
  logic [TABLE_DEPTH-1:0] dup;

  assign accept = start && !busy;
  assign widen  = WIDE_W'(margin[MARGIN_W-1:2]);

  // order the relevant pair and widen it on both sides
  always_comb begin
    pa   = hint_kind[1] ? WIDE_W'($signed(y_start)) : WIDE_W'($signed(x_start));
    pb   = hint_kind[1] ? WIDE_W'($signed(y_end))   : WIDE_W'($signed(x_end));
    swap = pa > pb;
    query_next.band.kind      = hint_kind;
    query_next.band.lo        = swap ? pb[COORD_W-1:0] : pa[COORD_W-1:0];
    query_next.band.hi        = swap ? pa[COORD_W-1:0] : pb[COORD_W-1:0];
    query_next.band.start_tag = start_tag;
    query_next.band.end_tag   = end_tag;
    query_next.lo_w           = swap ? WIDE_W'(pb - widen) : WIDE_W'(pa - widen);
    query_next.hi_w           = swap ? WIDE_W'(pa + widen) : WIDE_W'(pb + widen);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query  <= query_next;
      q_func <= func;
    end
  end

  genvar i;
  generate
    for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      band_t  upstream;
      match_t m;
      if (i == 0) begin : g_head
        assign upstream = query.band;
      end else begin : g_link
        assign upstream = chain[i-1];
      end
      hbt_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .occupied (count > CNT_W'(i)),
        .band_in  (upstream),
        .query    (query),
        .band     (chain[i]),
        .match    (m)
      );
      assign hit[i] = m.hit;
      assign dup[i] = m.dup;
    end
  endgenerate

  hbt_pick u_pick (
    .hit  (hit),
    .dup  (dup),
    .pick (pick)
  );

  assign full     = (count == CNT_W'(TABLE_DEPTH));
  assign insert   = (q_func == FUNC_ADD) && !pick.any_hit && !full;
  assign shift_en = (state == S_DEC) && insert;

  always_comb begin
    count_next  = count;
    status_next = STAT_INSERTED;
    if (q_func == FUNC_CLEAR) begin
      count_next  = '0;
      status_next = STAT_CLEARED;
    end else if (pick.any_hit) begin
      status_next = pick.dup ? STAT_DUPLICATE : STAT_CONFLICT;
    end else if (full) begin
      status_next = STAT_FULL;
    end else begin
      count_next  = count + CNT_W'(1);
      status_next = STAT_INSERTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      busy        <= 1'b0;
      done        <= 1'b0;
      count       <= '0;
      status      <= STAT_INSERTED;
      entry_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            busy  <= 1'b1;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_DEC;
        end
        S_DEC: begin
          count       <= count_next;
          status      <= status_next;
          entry_count <= COUNT_OUT_W'(count_next);
          done        <= 1'b1;
          busy        <= 1'b0;
          state       <= S_IDLE;
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= MARGIN_RESET;
    end else if (band_margin_we) begin
      margin <= band_margin;
    end
  end

endmodule

/* rtl/hbt_checker.sv */
// ----------------------------------------------------------------------------
// hbt_checker - port-level checks of the hint band table
// Watches request and result ports for turnaround and status consistency.
// ----------------------------------------------------------------------------
module hbt_checker
  import hbt_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input logic [2:0]             status,
  input logic [COUNT_OUT_W-1:0] entry_count
);

  // every accepted request is answered with done
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result missing three cycles after accept");

  // a result only appears once the block is free again
  assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // no result without a request in flight
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a pending request");

  assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_CLEARED) |-> (entry_count == '0))
    else $error("clear left entries");

  assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_INSERTED) |-> (entry_count != '0))
    else $error("insert reported an empty table");

endmodule

bind hint_band_table hbt_checker u_hbt_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .entry_count (entry_count)
);
